@@ hdl/roi_binary_threshold_counter_assert.svh @@
// Assertion macros for the ROI binary threshold counter.
// Included by roi_binary_threshold_counter.sv; no other dependencies.
`ifndef ROI_BINARY_THRESHOLD_COUNTER_ASSERT_SVH
`define ROI_BINARY_THRESHOLD_COUNTER_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define RBTC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define RBTC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/roi_btc_pkg.sv @@
// Shared types, constants and ROI clamping functions for the ROI binary
// threshold counter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package roi_btc_pkg;

    // Field widths
    localparam int DIM_W     = 13;
    localparam int PIX_W     = 8;
    localparam int CNT_W     = 25;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 4;
    localparam int MODE_W    = 2;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [PIX_W-1:0] PIX_WHITE = {PIX_W{1'b1}};
    localparam logic [PIX_W-1:0] PIX_BLACK = '0;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROI_LEFT     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROI_TOP      = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROI_WIDTH    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROI_HEIGHT   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MODE         = 4'd7;

    // Mode codes; the other codes are errors
    localparam logic [MODE_W-1:0] MODE_COPY      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_THRESHOLD = 2'd1;

    // Reset values of the configuration registers
    localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT = 13'd480;
    localparam logic [PIX_W-1:0]  RST_THRESHOLD    = 8'd128;

    // One clamped axis of the ROI
    typedef struct packed {
        logic [DIM_W-1:0] start;
        logic [DIM_W-1:0] len;
    } axis_t;

    // Frame and ROI geometry derived from the configuration
    typedef struct packed {
        logic [DIM_W-1:0] left;
        logic [DIM_W-1:0] top;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [DIM_W-1:0] right;     // left + width, exclusive
        logic [DIM_W-1:0] bottom;    // top + height, exclusive
        logic [DIM_W-1:0] last_col;  // effective frame width - 1
        logic [DIM_W-1:0] last_row;  // effective frame height - 1
    } geom_t;

    // Frame size: zero reads as one, above max_dim reads as max_dim
    function automatic logic [DIM_W-1:0] eff_dim(
        input logic [DIM_W-1:0] v,
        input int unsigned      max_dim
    );
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (32'(v) > max_dim) begin
            r = DIM_W'(max_dim);
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Clamp start to [0, dim], then length to the room left in the frame
    function automatic axis_t clamp_axis(
        input logic signed [CFG_W-1:0] pos,
        input logic signed [CFG_W-1:0] len,
        input logic [DIM_W-1:0]        dim
    );
        axis_t            a;
        logic [DIM_W-1:0] room;
        if (pos < 0) begin
            a.start = '0;
        end else if (pos > $signed(CFG_W'(dim))) begin
            a.start = dim;
        end else begin
            a.start = pos[DIM_W-1:0];
        end
        room = dim - a.start;
        if (len > $signed(CFG_W'(room))) begin
            a.len = room;
        end else begin
            a.len = len[DIM_W-1:0];
        end
        return a;
    endfunction

    // Full geometry; a non-positive ROI width or height selects the frame
    function automatic geom_t make_geom(
        input logic [DIM_W-1:0]        fw_raw,
        input logic [DIM_W-1:0]        fh_raw,
        input logic signed [CFG_W-1:0] left,
        input logic signed [CFG_W-1:0] top,
        input logic signed [CFG_W-1:0] width,
        input logic signed [CFG_W-1:0] height,
        input int unsigned             max_dim
    );
        geom_t            g;
        logic [DIM_W-1:0] fw;
        logic [DIM_W-1:0] fh;
        axis_t            ax;
        axis_t            ay;
        fw = eff_dim(fw_raw, max_dim);
        fh = eff_dim(fh_raw, max_dim);
        if (width <= 0 || height <= 0) begin
            ax.start = '0;
            ax.len   = fw;
            ay.start = '0;
            ay.len   = fh;
        end else begin
            ax = clamp_axis(left, width, fw);
            ay = clamp_axis(top, height, fh);
        end
        g.left     = ax.start;
        g.width    = ax.len;
        g.top      = ay.start;
        g.height   = ay.len;
        g.right    = ax.start + ax.len;
        g.bottom   = ay.start + ay.len;
        g.last_col = fw - DIM_W'(1);
        g.last_row = fh - DIM_W'(1);
        return g;
    endfunction

endpackage

`default_nettype wire

@@ hdl/roi_binary_threshold_counter.sv @@
// ROI binary threshold counter: top level, single module.
// Depends on roi_btc_pkg and roi_binary_threshold_counter_assert.svh.
//
//  Channel   Signals                                      Direction
//  s_        s_valid/s_ready, s_pixel_in                  pixel in
//  m_        m_valid/m_ready, m_pixel_out, flags, counts  result out
//  cfg_      cfg_wr_en, cfg_wr_index, cfg_wr_data         register write
//
// One pixel per clock while m_ready is high; an accepted pixel goes to the input
// register, then through threshold/count logic into the result register (m_valid).
// Clamped ROI geometry is recomputed into a register every cycle from the
// configuration. Synchronous active-low reset clears the position, the counts
// and the valid flags and loads the register defaults. A stalled m_ holds
// both stages; s_ready stays high while the input register can move on.
`timescale 1ns / 1ps
`default_nettype none

module roi_binary_threshold_counter #(
    parameter int unsigned MAX_DIM = 4096
) (
    input  wire                                    aclk,
    input  wire                                    aresetn,

    input  wire                                    cfg_wr_en,
    input  wire  [roi_btc_pkg::CFG_IDX_W-1:0]      cfg_wr_index,
    input  wire  [roi_btc_pkg::CFG_W-1:0]          cfg_wr_data,

    input  wire                                    s_valid,
    output logic                                   s_ready,
    input  wire  [roi_btc_pkg::PIX_W-1:0]          s_pixel_in,

    output logic                                   m_valid,
    input  wire                                    m_ready,
    output logic [roi_btc_pkg::PIX_W-1:0]          m_pixel_out,
    output logic                                   m_frame_end,
    output logic                                   m_mode_error,
    output logic [roi_btc_pkg::CNT_W-1:0]          m_white_count,
    output logic [roi_btc_pkg::CNT_W-1:0]          m_black_count,
    output logic [roi_btc_pkg::DIM_W-1:0]          m_clamped_left,
    output logic [roi_btc_pkg::DIM_W-1:0]          m_clamped_top,
    output logic [roi_btc_pkg::DIM_W-1:0]          m_clamped_width,
    output logic [roi_btc_pkg::DIM_W-1:0]          m_clamped_height
);

    import roi_btc_pkg::*;

    localparam int POS_W = $clog2(MAX_DIM);
    localparam int CMP_W = ((POS_W > DIM_W) ? POS_W : DIM_W) + 1;

    // Configuration registers
    logic [DIM_W-1:0]        frame_width_reg;
    logic [DIM_W-1:0]        frame_height_reg;
    logic signed [CFG_W-1:0] roi_left_reg;
    logic signed [CFG_W-1:0] roi_top_reg;
    logic signed [CFG_W-1:0] roi_width_reg;
    logic signed [CFG_W-1:0] roi_height_reg;
    logic [PIX_W-1:0]        threshold_reg;
    logic [MODE_W-1:0]       mode_reg;

    // Derived geometry
    geom_t geom_reg;
    geom_t geom_next;

    // Input stage
    logic             in_valid_reg;
    logic [PIX_W-1:0] in_pixel_reg;

    // Position and running totals
    logic [POS_W-1:0] col_reg,   col_next;
    logic [POS_W-1:0] row_reg,   row_next;
    logic [CNT_W-1:0] white_reg, white_next;
    logic [CNT_W-1:0] black_reg, black_next;

    // Result stage
    logic             out_valid_reg;
    logic [PIX_W-1:0] out_pixel_reg,   out_pixel_next;
    logic             out_fend_reg,    out_fend_next;
    logic             out_err_reg,     out_err_next;
    logic [CNT_W-1:0] out_white_reg,   out_white_next;
    logic [CNT_W-1:0] out_black_reg,   out_black_next;
    logic [DIM_W-1:0] out_left_reg,    out_left_next;
    logic [DIM_W-1:0] out_top_reg,     out_top_next;
    logic [DIM_W-1:0] out_width_reg,   out_width_next;
    logic [DIM_W-1:0] out_height_reg,  out_height_next;

    logic s_accept;
    logic advance;
    logic err;
    logic in_roi;
    logic is_white;
    logic last_col;
    logic last_row;
    logic fend;
    logic [CMP_W-1:0] col_w;
    logic [CMP_W-1:0] row_w;

    // Handshake: input register moves on when the result register frees up
    assign advance  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            roi_left_reg     <= '0;
            roi_top_reg      <= '0;
            roi_width_reg    <= '0;
            roi_height_reg   <= '0;
            threshold_reg    <= RST_THRESHOLD;
            mode_reg         <= MODE_COPY;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wr_data[DIM_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wr_data[DIM_W-1:0];
                REG_ROI_LEFT:     roi_left_reg     <= $signed(cfg_wr_data);
                REG_ROI_TOP:      roi_top_reg      <= $signed(cfg_wr_data);
                REG_ROI_WIDTH:    roi_width_reg    <= $signed(cfg_wr_data);
                REG_ROI_HEIGHT:   roi_height_reg   <= $signed(cfg_wr_data);
                REG_THRESHOLD:    threshold_reg    <= cfg_wr_data[PIX_W-1:0];
                REG_MODE:         mode_reg         <= cfg_wr_data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamped ROI, refreshed every cycle
    assign geom_next = make_geom(frame_width_reg, frame_height_reg, roi_left_reg,
                                 roi_top_reg, roi_width_reg, roi_height_reg, MAX_DIM);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            geom_reg <= make_geom(RST_FRAME_WIDTH, RST_FRAME_HEIGHT, '0, '0, '0, '0,
                                  MAX_DIM);
        end else begin
            geom_reg <= geom_next;
        end
    end

    // Per-pixel decision
    always_comb begin
        col_w    = CMP_W'(col_reg);
        row_w    = CMP_W'(row_reg);
        err      = (mode_reg != MODE_COPY) && (mode_reg != MODE_THRESHOLD);
        in_roi   = (col_w >= CMP_W'(geom_reg.left)) && (col_w < CMP_W'(geom_reg.right)) &&
                   (row_w >= CMP_W'(geom_reg.top))  && (row_w < CMP_W'(geom_reg.bottom));
        is_white = in_pixel_reg > threshold_reg;
        last_col = col_w >= CMP_W'(geom_reg.last_col);
        last_row = row_w >= CMP_W'(geom_reg.last_row);
        fend     = last_col && last_row;

        white_next = white_reg;
        black_next = black_reg;
        if (err) begin
            out_pixel_next = PIX_BLACK;
        end else if (mode_reg == MODE_THRESHOLD && in_roi) begin
            if (is_white) begin
                out_pixel_next = PIX_WHITE;
                if (white_reg != COUNT_MAX) begin
                    white_next = white_reg + CNT_W'(1);
                end
            end else begin
                out_pixel_next = PIX_BLACK;
                if (black_reg != COUNT_MAX) begin
                    black_next = black_reg + CNT_W'(1);
                end
            end
        end else begin
            out_pixel_next = in_pixel_reg;
        end

        // Report fields only on the frame's last pixel
        out_fend_next   = fend;
        out_err_next    = err;
        out_white_next  = (fend && !err) ? white_next : '0;
        out_black_next  = (fend && !err) ? black_next : '0;
        out_left_next   = fend ? geom_reg.left   : '0;
        out_top_next    = fend ? geom_reg.top    : '0;
        out_width_next  = fend ? geom_reg.width  : '0;
        out_height_next = fend ? geom_reg.height : '0;

        // Raster position
        if (last_col) begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + POS_W'(1);
        end else begin
            col_next = col_reg + POS_W'(1);
            row_next = row_reg;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            white_reg     <= '0;
            black_reg     <= '0;
        end else begin
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                col_reg       <= col_next;
                row_reg       <= row_next;
                white_reg     <= fend ? '0 : white_next;
                black_reg     <= fend ? '0 : black_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_pixel_reg <= s_pixel_in;
        end
        if (advance) begin
            out_pixel_reg  <= out_pixel_next;
            out_fend_reg   <= out_fend_next;
            out_err_reg    <= out_err_next;
            out_white_reg  <= out_white_next;
            out_black_reg  <= out_black_next;
            out_left_reg   <= out_left_next;
            out_top_reg    <= out_top_next;
            out_width_reg  <= out_width_next;
            out_height_reg <= out_height_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_pixel_out      = out_pixel_reg;
    assign m_frame_end      = out_fend_reg;
    assign m_mode_error     = out_err_reg;
    assign m_white_count    = out_white_reg;
    assign m_black_count    = out_black_reg;
    assign m_clamped_left   = out_left_reg;
    assign m_clamped_top    = out_top_reg;
    assign m_clamped_width  = out_width_reg;
    assign m_clamped_height = out_height_reg;

    // Assertions
`include "roi_binary_threshold_counter_assert.svh"

    // Report fields stay zero away from the frame end
    `RBTC_ASSERT_NOW(a_report_only_at_end, aclk, aresetn, m_valid && !m_frame_end, m_white_count == '0 && m_black_count == '0 && m_clamped_width == '0 && m_clamped_height == '0, "report fields set on a non-final pixel")

    // Frame end wraps the position and clears the totals
    `RBTC_ASSERT_NEXT(a_frame_wrap, aclk, aresetn, advance && fend, col_reg == '0 && row_reg == '0 && white_reg == '0 && black_reg == '0, "frame end did not restart position and totals")

    // Clamped ROI stays inside the effective frame
    `RBTC_ASSERT_NOW(a_roi_in_frame, aclk, aresetn, 1'b1, geom_reg.left <= geom_reg.right && geom_reg.right <= geom_reg.last_col + DIM_W'(1) && geom_reg.bottom <= geom_reg.last_row + DIM_W'(1), "clamped ROI outside the frame")

endmodule

`default_nettype wire
